// ----- design/stn_pkg.sv -----
`default_nettype none

package stn_pkg;

   // Largest number of links a node may have; the port fields limit it to 16.
   localparam int MAX_PORTS = 16;
   localparam logic [4:0] PORT_CAP = (MAX_PORTS < 16) ? 5'(MAX_PORTS) : 5'd16;

   // Configuration register indexes (word address bit 2).
   localparam logic REG_PORT_COUNT   = 1'b0;
   localparam logic REG_IS_INITIATOR = 1'b1;

   typedef enum logic [1:0] {
      NS_IDLE   = 2'd0,
      NS_INIT   = 2'd1,
      NS_ACTIVE = 2'd2,
      NS_DONE   = 2'd3
   } node_status_type;

   typedef enum logic [1:0] {
      EV_START = 2'd0,
      EV_QUERY = 2'd1,
      EV_YES   = 2'd2,
      EV_NO    = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      KIND_QUERY = 2'd0,
      KIND_YES   = 2'd1,
      KIND_NO    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CS_IDLE  = 2'd0,
      CS_EVAL  = 2'd1,
      CS_HEAD  = 2'd2,
      CS_SWEEP = 2'd3
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
      logic load_head;
      logic load_sweep;
      logic advance;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_head;
      logic sweep_pending;
      logic sweep_emit;
      logic sweep_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- design/stn_ctrl.sv -----
`default_nettype none

module stn_ctrl
   import stn_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // The output register can take a word when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_tvalid) state_in = CS_EVAL;
         end
         CS_EVAL: begin
            state_in = status.has_head ? CS_HEAD : CS_SWEEP;
         end
         CS_HEAD: begin
            if (out_free) state_in = status.sweep_pending ? CS_SWEEP : CS_IDLE;
         end
         CS_SWEEP: begin
            if (status.sweep_emit && out_free && status.sweep_last) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // Outputs and commands.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         CS_EVAL: begin
            cmd.commit = 1'b1;
         end
         CS_HEAD: begin
            cmd.load_head = out_free;
         end
         CS_SWEEP: begin
            cmd.load_sweep = status.sweep_emit && out_free;
            cmd.advance    = !status.sweep_emit || out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result word valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_head || cmd.load_sweep) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/stn_dp.sv -----
`default_nettype none

module stn_dp
   import stn_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctrl_cmd_type cmd,
   output dp_status_type     status,
   input  wire logic [1:0]   req_mode,
   input  wire logic [3:0]   req_arrival_port,
   input  wire logic         csr_write,
   input  wire logic         csr_index,
   input  wire logic [31:0]  csr_wdata,
   output logic [31:0]       csr_rdata,
   output logic              rsp_send_valid,
   output logic [3:0]        rsp_out_port,
   output logic [1:0]        rsp_out_kind,
   output logic              rsp_last,
   output logic [1:0]        rsp_node_status,
   output logic              rsp_event_error,
   output logic [15:0]       rsp_tree_ports,
   output logic              rsp_is_root,
   output logic [3:0]        rsp_parent_port
);

   // Configuration registers.
   logic [4:0] port_count_ff;
   logic       is_init_ff;

   // Node state.
   node_status_type node_ff, node_in;
   logic [3:0]      parent_ff, parent_in;
   logic [4:0]      reply_ff, reply_in;
   logic [15:0]     mask_ff, mask_in;
   logic            root_ff, root_in;

   // Captured event.
   event_type  mode_ff;
   logic [3:0] port_ff;

   // Plan of the step: an optional head word, then an optional query sweep.
   logic       head_send_ff, head_send_in;
   logic [3:0] head_port_ff, head_port_in;
   kind_type   head_kind_ff, head_kind_in;
   logic       head_err_ff, head_err_in;
   logic       has_head;
   logic       sweep_en_ff, sweep_en_in;
   logic       skip_en_ff, skip_en_in;
   logic [3:0] last_p_ff, last_p_in;
   logic [3:0] p_ff;

   // Result word register.
   logic       out_send_ff;
   logic [3:0] out_port_ff;
   kind_type   out_kind_ff;
   logic       out_last_ff;
   logic [1:0] out_status_ff;
   logic       out_err_ff;
   logic [15:0] out_mask_ff;
   logic       out_root_ff;
   logic [3:0] out_parent_ff;

   logic [4:0]      np;
   logic [3:0]      np_m1;
   logic            port_ok;
   node_status_type st_eff;
   logic [4:0]      reply_sat;
   logic [4:0]      reply_first;
   logic [15:0]     port_bit;

   // Effective port count and status as seen by the protocol.
   assign np          = (port_count_ff > PORT_CAP) ? PORT_CAP : port_count_ff;
   assign np_m1       = 4'(np - 5'd1);
   assign port_ok     = {1'b0, port_ff} < np;
   assign st_eff      = (node_ff == NS_IDLE && is_init_ff) ? NS_INIT : node_ff;
   assign reply_sat   = (reply_ff != 5'd31) ? 5'(reply_ff + 5'd1) : reply_ff;
   assign reply_first = 5'(reply_ff + 5'd1);
   assign port_bit    = 16'd1 << port_ff;

   // Step evaluation: next state and the plan of words to send.
   always_comb begin
      node_in      = node_ff;
      parent_in    = parent_ff;
      reply_in     = reply_ff;
      mask_in      = mask_ff;
      root_in      = root_ff;
      head_send_in = 1'b0;
      head_port_in = 4'd0;
      head_kind_in = KIND_QUERY;
      head_err_in  = 1'b0;
      has_head     = 1'b1;
      sweep_en_in  = 1'b0;
      skip_en_in   = 1'b0;
      last_p_in    = np_m1;
      case (st_eff)
         NS_INIT: begin
            if (mode_ff != EV_START) begin
               head_err_in = 1'b1;
            end else begin
               root_in = 1'b1;
               node_in = NS_ACTIVE;
               if (np != 5'd0) begin
                  has_head    = 1'b0;
                  sweep_en_in = 1'b1;
               end
            end
         end
         NS_IDLE: begin
            if (!port_ok || mode_ff != EV_QUERY) begin
               head_err_in = 1'b1;
            end else begin
               parent_in    = port_ff;
               mask_in      = mask_ff | port_bit;
               reply_in     = reply_first;
               head_send_in = 1'b1;
               head_port_in = port_ff;
               head_kind_in = KIND_YES;
               if (reply_first >= np) begin
                  node_in = NS_DONE;
               end else begin
                  node_in     = NS_ACTIVE;
                  sweep_en_in = 1'b1;
                  skip_en_in  = 1'b1;
                  // The parent port is skipped; when it is the highest port
                  // the sweep ends one port earlier.
                  last_p_in   = (port_ff == np_m1) ? 4'(np_m1 - 4'd1) : np_m1;
               end
            end
         end
         NS_ACTIVE: begin
            if (!port_ok || mode_ff == EV_START) begin
               head_err_in = 1'b1;
            end else if (mode_ff == EV_QUERY) begin
               head_send_in = 1'b1;
               head_port_in = port_ff;
               head_kind_in = KIND_NO;
            end else begin
               if (mode_ff == EV_YES) mask_in = mask_ff | port_bit;
               reply_in = reply_sat;
               if (reply_sat >= np) node_in = NS_DONE;
            end
         end
         default: begin
            head_err_in = 1'b1;
         end
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         port_count_ff <= 5'd1;
         is_init_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PORT_COUNT:   port_count_ff <= csr_wdata[4:0];
            REG_IS_INITIATOR: is_init_ff    <= csr_wdata[0];
            default:          port_count_ff <= port_count_ff;
         endcase
      end
   end

   // Configuration reads.
   always_comb begin
      unique case (csr_index)
         REG_PORT_COUNT:   csr_rdata = {27'd0, port_count_ff};
         REG_IS_INITIATOR: csr_rdata = {31'd0, is_init_ff};
         default:          csr_rdata = 32'd0;
      endcase
   end

   // Node state and plan are committed together.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff     <= NS_IDLE;
         parent_ff   <= 4'd0;
         reply_ff    <= 5'd0;
         mask_ff     <= 16'd0;
         root_ff     <= 1'b0;
         sweep_en_ff <= 1'b0;
         skip_en_ff  <= 1'b0;
      end else if (cmd.commit) begin
         node_ff     <= node_in;
         parent_ff   <= parent_in;
         reply_ff    <= reply_in;
         mask_ff     <= mask_in;
         root_ff     <= root_in;
         sweep_en_ff <= sweep_en_in;
         skip_en_ff  <= skip_en_in;
      end
   end

   // Event capture, plan payload and sweep counter.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= event_type'(req_mode);
         port_ff <= req_arrival_port;
      end
      if (cmd.commit) begin
         head_send_ff <= head_send_in;
         head_port_ff <= head_port_in;
         head_kind_ff <= head_kind_in;
         head_err_ff  <= head_err_in;
         last_p_ff    <= last_p_in;
         p_ff         <= 4'd0;
      end else if (cmd.advance) begin
         p_ff <= 4'(p_ff + 4'd1);
      end
   end

   // Result word register; state fields already hold the post-step values.
   always_ff @(posedge clock) begin
      if (cmd.load_head || cmd.load_sweep) begin
         out_status_ff <= st_eff;
         out_mask_ff   <= mask_ff;
         out_root_ff   <= root_ff;
         out_parent_ff <= parent_ff;
      end
      if (cmd.load_head) begin
         out_send_ff <= head_send_ff;
         out_port_ff <= head_port_ff;
         out_kind_ff <= head_kind_ff;
         out_err_ff  <= head_err_ff;
         out_last_ff <= !sweep_en_ff;
      end else if (cmd.load_sweep) begin
         out_send_ff <= 1'b1;
         out_port_ff <= p_ff;
         out_kind_ff <= KIND_QUERY;
         out_err_ff  <= 1'b0;
         out_last_ff <= status.sweep_last;
      end
   end

   assign status.has_head      = has_head;
   assign status.sweep_pending = sweep_en_ff;
   assign status.sweep_emit    = !(skip_en_ff && p_ff == parent_ff);
   assign status.sweep_last    = (p_ff == last_p_ff);

   assign rsp_send_valid  = out_send_ff;
   assign rsp_out_port    = out_port_ff;
   assign rsp_out_kind    = out_kind_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_node_status = out_status_ff;
   assign rsp_event_error = out_err_ff;
   assign rsp_tree_ports  = out_mask_ff;
   assign rsp_is_root     = out_root_ff;
   assign rsp_parent_port = out_parent_ff;

endmodule

`default_nettype wire

// ----- design/shout_spanning_tree_node_core.sv -----
// Sequence: a word is accepted, evaluated in the next cycle, and its first result is
// loaded into the result register once that register is free. Throughput: one item
// at a time; its n results are sent one port per cycle while the receiver does not
// stall, and the parent port is skipped during a flood. Synchronous reset returns
// the node to idle, clears the tree state, sets port_count 1, is_initiator 0.
`default_nettype none

module shout_spanning_tree_node_core
   import stn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input words.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [3:0] arrival_port, [7:4] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] mode
   // Result words.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [3:0] out_port, [5:4] node_status,
                                         // [21:6] tree_ports, [22] is_root,
                                         // [26:23] parent_port, [31:27] zero
   output logic [3:0]       rsp_tuser,   // [0] send_valid, [2:1] out_kind,
                                         // [3] event_error
   output logic             rsp_tlast,
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          csr_write;
   logic          send_valid;
   logic [3:0]    out_port;
   logic [1:0]    out_kind;
   logic [1:0]    node_status;
   logic          event_error;
   logic [15:0]   tree_ports;
   logic          is_root;
   logic [3:0]    parent_port;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   stn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   stn_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_tuser),
      .req_arrival_port (req_tdata[3:0]),
      .csr_write        (csr_write),
      .csr_index        (csr_paddr[2]),
      .csr_wdata        (csr_pwdata),
      .csr_rdata        (csr_prdata),
      .rsp_send_valid   (send_valid),
      .rsp_out_port     (out_port),
      .rsp_out_kind     (out_kind),
      .rsp_last         (rsp_tlast),
      .rsp_node_status  (node_status),
      .rsp_event_error  (event_error),
      .rsp_tree_ports   (tree_ports),
      .rsp_is_root      (is_root),
      .rsp_parent_port  (parent_port)
   );

   // Pack the result word.
   assign rsp_tdata = {5'd0, parent_port, is_root, tree_ports, node_status, out_port};
   assign rsp_tuser = {event_error, out_kind, send_valid};

endmodule

`default_nettype wire

// ----- design/stn_checker.sv -----
`default_nettype none

module stn_checker
   import stn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [3:0]  rsp_tuser,
   input  wire logic        rsp_tlast
);

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // An error word sends nothing and closes the step.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> !rsp_tuser[0] && rsp_tlast)
      else $error("error word sends a message or is not last");

   // A word that sends nothing is always the only word of its step.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tuser[2:1] == KIND_QUERY
         && rsp_tdata[3:0] == 4'd0)
      else $error("empty word carries a message or is not last");

   // The root has left the idle status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22] |-> rsp_tdata[5:4] == NS_ACTIVE
         || rsp_tdata[5:4] == NS_DONE)
      else $error("root node reports idle status");

endmodule

bind shout_spanning_tree_node_core stn_checker u_stn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- bench/shout_spanning_tree_node_core_test.sv -----
`timescale 1ns / 100ps

module shout_spanning_tree_node_core_test;
   import stn_pkg::*;

   localparam int LONG_HOLD = 300;
   localparam int WORDS_PER_PHASE = 80;

   typedef enum int {
      GAPS_NONE,
      GAPS_SENDER,
      GAPS_RECEIVER,
      GAPS_BOTH
   } gap_mode_type;

   typedef struct packed {
      event_type  mode;
      logic [3:0] port;
   } node_event_type;

   typedef struct packed {
      logic            send_valid;
      logic [3:0]      out_port;
      kind_type        out_kind;
      logic            last;
      node_status_type status;
      logic            event_error;
      logic [15:0]     tree_ports;
      logic            is_root;
      logic [3:0]      parent_port;
   } message_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow of the node's registers and protocol state.
   logic [4:0]      link_count_cfg = 5'd1;
   logic            initiator_cfg = 1'b0;
   node_status_type node_phase = NS_IDLE;
   logic [3:0]      parent_link = '0;
   logic [4:0]      replies_seen = '0;
   logic [15:0]     tree_links = '0;
   logic            root_seen = 1'b0;

   node_event_type   pending_events [$];
   message_word_type due_messages [$];
   node_event_type   next_event;
   gap_mode_type     gap_mode = GAPS_NONE;
   int               fail_count = 0;
   int               hold_requests = 0;
   int               holds_served = 0;
   int               hold_left = 0;

   shout_spanning_tree_node_core DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Number of links the node really uses.
   function automatic logic [4:0] usable_links();
      return (link_count_cfg > PORT_CAP) ? PORT_CAP : link_count_cfg;
   endfunction

   // An idle node that is set up as initiator reports the initiator status.
   function automatic node_status_type reported_status();
      if (node_phase == NS_IDLE && initiator_cfg) return NS_INIT;
      return node_phase;
   endfunction

   function automatic void count_reply(logic [4:0] links);
      if (replies_seen < 5'd31) replies_seen = replies_seen + 5'd1;
      if (replies_seen >= links) node_phase = NS_DONE;
   endfunction

   // Advance the shadow node by one event and queue the messages it sends.
   function automatic void predict_node_step(event_type mode, logic [3:0] port);
      logic [4:0]       links;
      node_status_type  status_now;
      logic             invalid;
      logic [3:0]       send_port [16];
      kind_type         send_kind [16];
      int               sends;
      message_word_type word;
      links = usable_links();
      status_now = reported_status();
      invalid = 1'b0;
      sends = 0;
      if (status_now == NS_INIT) begin
         if (mode != EV_START) begin
            invalid = 1'b1;
         end else begin
            root_seen = 1'b1;
            for (int p = 0; p < links; p++) begin
               send_port[sends] = p[3:0];
               send_kind[sends] = KIND_QUERY;
               sends++;
            end
            node_phase = NS_ACTIVE;
         end
      end else if (status_now == NS_DONE || {1'b0, port} >= links) begin
         invalid = 1'b1;
      end else if (status_now == NS_IDLE) begin
         if (mode != EV_QUERY) begin
            invalid = 1'b1;
         end else begin
            // Join the tree below the sender of the first query.
            parent_link = port;
            tree_links[port] = 1'b1;
            send_port[0] = port;
            send_kind[0] = KIND_YES;
            sends = 1;
            replies_seen = replies_seen + 5'd1;
            if (replies_seen >= links) begin
               node_phase = NS_DONE;
            end else begin
               for (int p = 0; p < links; p++) begin
                  if (p[3:0] != port) begin
                     send_port[sends] = p[3:0];
                     send_kind[sends] = KIND_QUERY;
                     sends++;
                  end
               end
               node_phase = NS_ACTIVE;
            end
         end
      end else begin
         case (mode)
            EV_START: invalid = 1'b1;
            EV_QUERY: begin
               send_port[0] = port;
               send_kind[0] = KIND_NO;
               sends = 1;
            end
            EV_YES: begin
               tree_links[port] = 1'b1;
               count_reply(links);
            end
            default: count_reply(links);
         endcase
      end

      // A step that sends nothing still reports one word.
      for (int k = 0; k < ((sends == 0) ? 1 : sends); k++) begin
         word.send_valid = (sends != 0);
         word.out_port = (sends != 0) ? send_port[k] : 4'd0;
         word.out_kind = (sends != 0) ? send_kind[k] : KIND_QUERY;
         word.last = (sends == 0) || (k == sends - 1);
         word.status = reported_status();
         word.event_error = invalid;
         word.tree_ports = tree_links;
         word.is_root = root_seen;
         word.parent_port = parent_link;
         due_messages.insert(due_messages.size(), word);
      end
   endfunction

   function automatic string describe(message_word_type w);
      return $sformatf({"send=%0d port=%0d kind=%0d last=%0d status=%0d err=%0d",
                        " tree=%h root=%0d parent=%0d"},
                       w.send_valid, w.out_port, w.out_kind, w.last, w.status,
                       w.event_error, w.tree_ports, w.is_root, w.parent_port);
   endfunction

   function automatic int sender_gap_percent();
      case (gap_mode)
         GAPS_SENDER: return 63;
         GAPS_BOTH:   return 37;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_percent();
      case (gap_mode)
         GAPS_RECEIVER: return 63;
         GAPS_BOTH:     return 37;
         default:       return 0;
      endcase
   endfunction

   // Event driver: predicts on acceptance and offers the next pending word.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_node_step(event_type'(req_tuser), req_tdata[3:0]);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() != 0 &&
                $urandom_range(0, 99) >= sender_gap_percent()) begin
               next_event = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_event.mode;
               req_tdata <= {4'b0000, next_event.port};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness, with an occasional long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         holds_served <= 0;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_percent());
      end
   end

   // Message monitor: every accepted word is checked against the oldest due one.
   always @(posedge clock) begin
      message_word_type got;
      message_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.send_valid = rsp_tuser[0];
         got.out_port = rsp_tdata[3:0];
         got.out_kind = kind_type'(rsp_tuser[2:1]);
         got.last = rsp_tlast;
         got.status = node_status_type'(rsp_tdata[5:4]);
         got.event_error = rsp_tuser[3];
         got.tree_ports = rsp_tdata[21:6];
         got.is_root = rsp_tdata[22];
         got.parent_port = rsp_tdata[26:23];
         if (due_messages.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected word: %s", describe(got));
         end else begin
            want = due_messages.pop_front();
            if (got.send_valid !== want.send_valid || got.out_port !== want.out_port ||
                got.out_kind !== want.out_kind || got.last !== want.last ||
                got.status !== want.status || got.event_error !== want.event_error ||
                got.tree_ports !== want.tree_ports || got.is_root !== want.is_root ||
                got.parent_port !== want.parent_port) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch at %0t: expected %s", $realtime, describe(want));
                  $display("                   actual %s", describe(got));
               end
            end
         end
      end
   end

   function automatic void add_event(event_type mode, logic [3:0] port);
      node_event_type ev;
      ev.mode = mode;
      ev.port = port;
      pending_events.insert(pending_events.size(), ev);
   endfunction

   // Mostly in-range queries, some start ticks and stray ports, few replies.
   function automatic void add_random_event();
      int         pick;
      logic [4:0] links;
      links = usable_links();
      if (links == 5'd0) links = 5'd1;
      pick = $urandom_range(0, 999);
      if (pick < 25)
         add_event($urandom_range(0, 1) ? EV_YES : EV_NO,
                   4'($urandom_range(0, links - 1)));
      else if (pick < 125)
         add_event(EV_START, 4'($urandom_range(0, 15)));
      else if (pick < 250)
         add_event(EV_QUERY, 4'($urandom_range(0, 15)));
      else
         add_event(EV_QUERY, 4'($urandom_range(0, links - 1)));
   endfunction

   task automatic write_register(input logic index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_PORT_COUNT) link_count_cfg = value[4:0];
      else initiator_cfg = value[0];
   endtask

   task automatic wait_until_quiet();
      while (pending_events.size() != 0 || req_tvalid || due_messages.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Stimulus sequence.
   initial begin
      logic join_as_root;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle node with the reset setup: only an in-range query is valid.
      add_event(EV_START, 4'd0);
      add_event(EV_YES, 4'd0);
      add_event(EV_NO, 4'd0);
      add_event(EV_QUERY, 4'd1);
      add_event(EV_QUERY, 4'd15);
      wait_until_quiet();

      // Initiator with no links rejects everything but a start tick.
      write_register(REG_IS_INITIATOR, 32'd1);
      write_register(REG_PORT_COUNT, 32'd0);
      add_event(EV_QUERY, 4'd0);
      add_event(EV_YES, 4'd15);
      add_event(EV_NO, 4'd0);
      wait_until_quiet();

      // The node leaves idle only once, either as root or by joining.
      join_as_root = 1'($urandom_range(0, 1));
      write_register(REG_PORT_COUNT, 32'd31);
      write_register(REG_IS_INITIATOR, {31'd0, join_as_root});
      if (join_as_root) add_event(EV_START, 4'd9);
      else add_event(EV_QUERY, 4'($urandom_range(0, 15)));
      add_event(EV_START, 4'd0);
      add_event(EV_QUERY, 4'd0);
      add_event(EV_QUERY, 4'd15);
      add_event(EV_YES, 4'd15);
      add_event(EV_NO, 4'd0);
      add_event(EV_YES, 4'd0);
      wait_until_quiet();

      // Random traffic while active, one idling pattern per phase.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_register(REG_PORT_COUNT, 32'd16);
            1: write_register(REG_PORT_COUNT, 32'd31);
            2: write_register(REG_PORT_COUNT, 32'd12);
            default: write_register(REG_PORT_COUNT, 32'd16);
         endcase
         gap_mode = gap_mode_type'(phase);
         if (phase == 0) hold_requests++;
         for (int n = 0; n < WORDS_PER_PHASE; n++) add_random_event();
         wait_until_quiet();
      end

      // Fewer links mid-protocol: the next reply completes the node.
      write_register(REG_PORT_COUNT, 32'($urandom_range(1, 8)));
      gap_mode = GAPS_BOTH;
      add_event(EV_NO, 4'd0);
      add_event(EV_YES, 4'd0);
      for (int n = 0; n < 8; n++) add_random_event();
      wait_until_quiet();
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
